// ===== rtl/qte_pkg.sv =====
// Shared types, constants and the arctangent table for the quaternion to Euler converter.
// No dependencies; imported by the top level and by the CORDIC lane.
`timescale 1ns / 1ps

package qte_pkg;

    // Width of the CORDIC vector coordinates and of the angle accumulator.
    localparam int unsigned CORDIC_W  = 37;
    localparam int unsigned ANGLE_ZW  = 27;
    localparam int unsigned ANGLE_OW  = ANGLE_ZW - 9;
    localparam int unsigned TABLE_LEN = 24;

    // 180 degrees in degrees * 2^16.
    localparam logic signed [ANGLE_ZW-1:0] DEG180 = ANGLE_ZW'(180 * 65536);

    typedef logic signed [CORDIC_W-1:0] t_coord;
    typedef logic signed [ANGLE_ZW-1:0] t_zacc;
    typedef logic signed [ANGLE_OW-1:0] t_angle;

    // atan(2^-i) in degrees * 2^16, rounded.
    function automatic t_zacc qte_atan(input logic [4:0] idx);
        t_zacc v;
        case (idx)
            5'd0:    v = ANGLE_ZW'(2949120);
            5'd1:    v = ANGLE_ZW'(1740967);
            5'd2:    v = ANGLE_ZW'(919879);
            5'd3:    v = ANGLE_ZW'(466945);
            5'd4:    v = ANGLE_ZW'(234379);
            5'd5:    v = ANGLE_ZW'(117304);
            5'd6:    v = ANGLE_ZW'(58666);
            5'd7:    v = ANGLE_ZW'(29335);
            5'd8:    v = ANGLE_ZW'(14668);
            5'd9:    v = ANGLE_ZW'(7334);
            5'd10:   v = ANGLE_ZW'(3667);
            5'd11:   v = ANGLE_ZW'(1833);
            5'd12:   v = ANGLE_ZW'(917);
            5'd13:   v = ANGLE_ZW'(458);
            5'd14:   v = ANGLE_ZW'(229);
            5'd15:   v = ANGLE_ZW'(115);
            5'd16:   v = ANGLE_ZW'(57);
            5'd17:   v = ANGLE_ZW'(29);
            5'd18:   v = ANGLE_ZW'(14);
            5'd19:   v = ANGLE_ZW'(7);
            5'd20:   v = ANGLE_ZW'(4);
            5'd21:   v = ANGLE_ZW'(2);
            5'd22:   v = ANGLE_ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC lane computing atan2(y, x) in degrees * 128.
// Depends on qte_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module qte_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qte_pkg::t_coord i_y,
    input  qte_pkg::t_coord i_x,
    output qte_pkg::t_angle o_angle
);
    import qte_pkg::*;

    localparam int unsigned N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    t_coord r_x [0:N];
    t_coord r_y [0:N];
    t_zacc  r_z [0:N];
    logic   r_zero [0:N];

    t_zacc  w_round;

    // Entry stage: fold the left half plane onto the right one.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_z[0] <= (i_y >= 0) ? DEG180 : -DEG180;
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
            end else begin
                r_z[0] <= '0;
                r_x[0] <= i_x;
                r_y[0] <= i_y;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_step
        t_coord w_xs;
        t_coord w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + qte_atan(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - qte_atan(5'(i));
                end
            end
        end
    end

    // Round half up to degrees * 128; both operands zero give zero.
    assign w_round = r_z[N] + ANGLE_ZW'(256);
    assign o_angle = r_zero[N] ? '0 : w_round[ANGLE_ZW-1:9];

endmodule

// ===== rtl/quaternion_to_euler_angles_core.sv =====
// Throughput: one item per cycle while no result is held at the output;
// 10 multipliers, a 29-stage square root and three CORDIC lanes.
// A held result freezes the whole pipeline; the input side stalls only then.
// Reset (synchronous, active low) clears the valid bits; data registers are not reset.
// Top level of the quaternion to Euler converter; depends on qte_pkg and qte_cordic.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_core #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_w_part,
    input  logic signed [15:0] i_x_part,
    input  logic signed [15:0] i_y_part,
    input  logic signed [15:0] i_z_part,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_psi_angle,
    output logic signed [14:0] o_theta_angle,
    output logic signed [15:0] o_phi_angle,
    output logic               o_asin_clamped
);
    import qte_pkg::*;

    localparam int unsigned N      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int unsigned SQ_N   = 29;
    localparam int unsigned DLY    = SQ_N + 2;
    localparam int unsigned FDLY   = DLY + N + 1;
    localparam int unsigned LAT    = 35 + N;
    localparam logic [56:0] ONE_SQ = 57'(1) << 56;
    localparam logic signed [34:0] ONE_Q28 = 35'(1) << 28;

    logic en;
    logic [LAT-1:0] r_vld;

    logic signed [31:0] r_p12, r_p03, r_p00, r_p11, r_p33, r_p23, r_p01, r_p13, r_p02;
    logic signed [34:0] r_py, r_px, r_fy, r_fx;
    logic signed [29:0] r_s;
    logic               r_flag;
    logic signed [34:0] n_s;
    logic [56:0]        r_sq;
    logic [56:0]        r_n [0:SQ_N];
    logic [57:0]        r_r [0:SQ_N];

    logic signed [34:0] r_dpy [0:DLY-1];
    logic signed [34:0] r_dpx [0:DLY-1];
    logic signed [34:0] r_dfy [0:DLY-1];
    logic signed [34:0] r_dfx [0:DLY-1];
    logic signed [29:0] r_ds  [0:DLY-1];
    logic               r_dfl [0:FDLY-1];

    t_angle w_psi, w_theta, w_phi;
    logic signed [ANGLE_OW:0] w_neg;

    // The pipeline advances unless a finished item is held at the output.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Products of the quaternion components.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p12 <= i_x_part * i_y_part;
            r_p03 <= i_w_part * i_z_part;
            r_p00 <= i_w_part * i_w_part;
            r_p11 <= i_x_part * i_x_part;
            r_p33 <= i_z_part * i_z_part;
            r_p23 <= i_y_part * i_z_part;
            r_p01 <= i_w_part * i_x_part;
            r_p13 <= i_x_part * i_z_part;
            r_p02 <= i_w_part * i_y_part;
        end
    end

    // Atan2 operands, the sine argument and its clamp to the unit range.
    assign n_s = 35'(r_p13 + 35'(r_p02)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_py <= (35'(r_p12) - 35'(r_p03)) <<< 1;
            r_px <= ((35'(r_p00) + 35'(r_p11)) <<< 1) - ONE_Q28;
            r_fy <= (35'(r_p23) - 35'(r_p01)) <<< 1;
            r_fx <= ((35'(r_p00) + 35'(r_p33)) <<< 1) - ONE_Q28;
            if (n_s > ONE_Q28) begin
                r_s    <= 30'(ONE_Q28);
                r_flag <= 1'b1;
            end else if (n_s < -ONE_Q28) begin
                r_s    <= -30'(ONE_Q28);
                r_flag <= 1'b1;
            end else begin
                r_s    <= n_s[29:0];
                r_flag <= 1'b0;
            end
        end
    end

    // Square of the sine, then the radicand for the cosine.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq   <= 57'(r_s * r_s);
            r_n[0] <= ONE_SQ - r_sq;
            r_r[0] <= '0;
        end
    end

    // Digit-by-digit integer square root, one result bit per stage.
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [57:0] BIT = 58'(1) << (56 - 2 * k);
        logic [57:0] w_sum;
        assign w_sum = r_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if ({1'b0, r_n[k]} >= w_sum) begin
                    r_n[k+1] <= r_n[k] - w_sum[56:0];
                    r_r[k+1] <= (r_r[k] >> 1) + BIT;
                end else begin
                    r_n[k+1] <= r_n[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

    // Delay lines that keep the other operands level with the square root.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dpy[0] <= r_py;
            r_dpx[0] <= r_px;
            r_dfy[0] <= r_fy;
            r_dfx[0] <= r_fx;
            r_ds[0]  <= r_s;
            r_dfl[0] <= r_flag;
            for (int j = 1; j < DLY; j++) begin
                r_dpy[j] <= r_dpy[j-1];
                r_dpx[j] <= r_dpx[j-1];
                r_dfy[j] <= r_dfy[j-1];
                r_dfx[j] <= r_dfx[j-1];
                r_ds[j]  <= r_ds[j-1];
            end
            for (int j = 1; j < FDLY; j++) begin
                r_dfl[j] <= r_dfl[j-1];
            end
        end
    end

    // Three CORDIC lanes in parallel.
    qte_cordic #(.STEPS(N)) u_psi (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CORDIC_W'(r_dpy[DLY-1])),
        .i_x     (CORDIC_W'(r_dpx[DLY-1])),
        .o_angle (w_psi)
    );

    qte_cordic #(.STEPS(N)) u_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CORDIC_W'(r_ds[DLY-1])),
        .i_x     (CORDIC_W'(signed'({1'b0, r_r[SQ_N][28:0]}))),
        .o_angle (w_theta)
    );

    qte_cordic #(.STEPS(N)) u_phi (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CORDIC_W'(r_dfy[DLY-1])),
        .i_x     (CORDIC_W'(r_dfx[DLY-1])),
        .o_angle (w_phi)
    );

    assign w_neg = -(ANGLE_OW + 1)'(w_theta);

    // Output register with saturation to the angle ranges.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_psi > 23040) begin
                o_psi_angle <= 16'sd23040;
            end else if (w_psi < -23040) begin
                o_psi_angle <= -16'sd23040;
            end else begin
                o_psi_angle <= w_psi[15:0];
            end
            if (w_phi > 23040) begin
                o_phi_angle <= 16'sd23040;
            end else if (w_phi < -23040) begin
                o_phi_angle <= -16'sd23040;
            end else begin
                o_phi_angle <= w_phi[15:0];
            end
            if (w_neg > 11520) begin
                o_theta_angle <= 15'sd11520;
            end else if (w_neg < -11520) begin
                o_theta_angle <= -15'sd11520;
            end else begin
                o_theta_angle <= w_neg[14:0];
            end
            o_asin_clamped <= r_dfl[FDLY-1];
        end
    end

endmodule

// ===== rtl/qte_checker.sv =====
// Port-level checks for the quaternion to Euler converter, bound to its top level.
// Depends only on the ports of quaternion_to_euler_angles_core.
`timescale 1ns / 1ps

module qte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_psi_angle,
    input logic signed [14:0] o_theta_angle,
    input logic signed [15:0] o_phi_angle
);

    // A result item waiting on a stall is not dropped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item lost while stalled");

    // The input stalls only while a result item is held.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // Theta stays within plus or minus 90 degrees.
    a_theta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_theta_angle >= -15'sd11520) && (o_theta_angle <= 15'sd11520))
        else $error("theta out of range");

    // Psi and phi stay within plus or minus 180 degrees.
    a_atan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_psi_angle >= -16'sd23040) && (o_psi_angle <= 16'sd23040)
                 && (o_phi_angle >= -16'sd23040) && (o_phi_angle <= 16'sd23040))
        else $error("psi or phi out of range");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_psi_angle   (o_psi_angle),
    .o_theta_angle (o_theta_angle),
    .o_phi_angle   (o_phi_angle)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for quaternion_to_euler_angles_core: random and directed quaternions.
// Depends on the RTL core only; predicts every angle with its own CORDIC model.
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS        = 16;
    localparam int LATENCY      = 35 + STEPS;
    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 400000;
    localparam longint ONE_Q28  = 64'sd1 << 28;
    localparam longint HALF_TURN = 64'sd180 * 65536;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct {
        logic signed [15:0] psi;
        logic signed [14:0] theta;
        logic signed [15:0] phi;
        logic               clamped;
    } t_euler;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_w_part;
    logic signed [15:0] i_x_part;
    logic signed [15:0] i_y_part;
    logic signed [15:0] i_z_part;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_psi_angle;
    logic signed [14:0] o_theta_angle;
    logic signed [15:0] o_phi_angle;
    logic               o_asin_clamped;

    t_quat  pending_quats[$];
    t_euler expected_angles[$];
    int     error_count;
    int     cycle_count;
    int     result_count;
    int     clamp_count;
    bit     stimulus_done;
    bit     sender_hold;
    bit     sender_quiet;
    bit     receiver_quiet;
    int     receiver_holdoff;
    bit     in_accepted;

    quaternion_to_euler_angles_core #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_w_part(i_w_part),
        .i_x_part(i_x_part),
        .i_y_part(i_y_part),
        .i_z_part(i_z_part),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_psi_angle(o_psi_angle),
        .o_theta_angle(o_theta_angle),
        .o_phi_angle(o_phi_angle),
        .o_asin_clamped(o_asin_clamped)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Floor shift for signed values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Arctangent in degrees per CORDIC step, times 2^16.
    function automatic longint atan_step_deg(int i);
        longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return steps[i];
    endfunction

    // Vectoring CORDIC atan2, result in degrees times 128 before saturation.
    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint xs;
        longint ys;
        int     n;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        n = (STEPS > 24) ? 24 : STEPS;
        for (int i = 0; i < n; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x += ys;
                y -= xs;
                acc += atan_step_deg(i);
            end else begin
                x -= ys;
                y += xs;
                acc -= atan_step_deg(i);
            end
        end
        return floor_shift(acc + 256, 9);
    endfunction

    // Integer square root, floor.
    function automatic longint floor_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 56;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Expected Euler angles for one quaternion.
    function automatic t_euler euler_from_quat(t_quat q);
        longint q0, q1, q2, q3, py, px, fy, fx, s, c;
        t_euler e;
        q0 = q.w;
        q1 = q.x;
        q2 = q.y;
        q3 = q.z;
        py = 2 * q1 * q2 - 2 * q0 * q3;
        px = 2 * q0 * q0 + 2 * q1 * q1 - ONE_Q28;
        fy = 2 * q2 * q3 - 2 * q0 * q1;
        fx = 2 * q0 * q0 + 2 * q3 * q3 - ONE_Q28;
        s = 2 * q1 * q3 + 2 * q0 * q2;
        e.clamped = 1'b0;
        if (s > ONE_Q28) begin
            s = ONE_Q28;
            e.clamped = 1'b1;
        end
        if (s < -ONE_Q28) begin
            s = -ONE_Q28;
            e.clamped = 1'b1;
        end
        c = floor_sqrt((64'd1 << 56) - 64'(s * s));
        e.psi = 16'(limit_to(vector_angle(py, px), 23040));
        e.theta = 15'(limit_to(-vector_angle(s, c), 11520));
        e.phi = 16'(limit_to(vector_angle(fy, fx), 23040));
        return e;
    endfunction

    function automatic t_quat make_quat(int w, int x, int y, int z);
        t_quat q;
        q.w = 16'(w);
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        return q;
    endfunction

    // Random quaternion: mostly near unit length, some anywhere in range, a few raw bits.
    function automatic t_quat random_quat();
        t_quat q;
        int    kind;
        real   a, b, c, d, n;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            a = $itor($signed($urandom_range(0, 2000))) - 1000.0;
            b = $itor($signed($urandom_range(0, 2000))) - 1000.0;
            c = $itor($signed($urandom_range(0, 2000))) - 1000.0;
            d = $itor($signed($urandom_range(0, 2000))) - 1000.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            q = make_quat($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
                          $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
        end else if (kind < 95) begin
            q = make_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                          $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        end else begin
            q = make_quat($urandom(), $urandom(), $urandom(), $urandom());
        end
        return q;
    endfunction

    // Stimulus: directed corners, a quiet pause, then random quaternions.
    initial begin
        int dir[19][4] = '{
            '{16384, 0, 0, 0}, '{-16384, 0, 0, 0}, '{0, 16384, 0, 0}, '{0, 0, 16384, 0},
            '{0, 0, 0, 16384}, '{0, 0, 0, 0}, '{16384, 16384, 16384, 16384},
            '{-16384, -16384, -16384, -16384}, '{11585, 0, 11585, 0},
            '{11585, 0, -11585, 0}, '{11585, 11585, 0, 0}, '{11585, 0, 0, 11585},
            '{16384, 0, 16384, 0}, '{-16384, 0, 16384, 0}, '{-32768, 32767, -32768, 32767},
            '{32767, -32768, 32767, -32768}, '{8192, 8192, 8192, 8192},
            '{8192, -8192, 8192, -8192}, '{1, -1, 1, -1}};
        i_rst_n = 1'b0;
        stimulus_done = 1'b0;
        sender_hold = 1'b0;
        foreach (dir[k]) pending_quats.push_back(make_quat(dir[k][0], dir[k][1],
                                                           dir[k][2], dir[k][3]));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_quats.size() == 0);
        // Sender pause until every result is back.
        sender_hold = 1'b1;
        wait (expected_angles.size() == 0);
        sender_hold = 1'b0;
        for (int k = 0; k < RANDOM_ITEMS; k++) pending_quats.push_back(random_quat());
        wait (pending_quats.size() == 0);
        @(negedge i_clk);
        stimulus_done = 1'b1;
    end

    // Driver: offers items at the falling edge, holds them until accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            {i_w_part, i_x_part, i_y_part, i_z_part} <= '0;
            sender_quiet <= 1'b0;
        end else begin
            sender_quiet <= (cycle_count > 600 && cycle_count < 1100);
            if (i_valid && !in_accepted) begin
                // Payload held.
            end else if (pending_quats.size() != 0 && !sender_hold &&
                         (sender_quiet || $urandom_range(0, 99) >= 25)) begin
                i_valid <= 1'b1;
                i_w_part <= pending_quats[0].w;
                i_x_part <= pending_quats[0].x;
                i_y_part <= pending_quats[0].y;
                i_z_part <= pending_quats[0].z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, one long hold-off, and a quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            receiver_holdoff <= 0;
            receiver_quiet <= 1'b0;
        end else begin
            receiver_quiet <= (cycle_count > 600 && cycle_count < 1100);
            if (cycle_count == 1400) receiver_holdoff <= 300;
            else if (receiver_holdoff != 0) receiver_holdoff <= receiver_holdoff - 1;
            if (receiver_holdoff != 0) i_stall <= 1'b1;
            else i_stall <= !receiver_quiet && ($urandom_range(0, 99) < 25);
        end
    end

    // Monitor: records accepted quaternions and checks results at the rising edge.
    always @(posedge i_clk) begin
        t_euler e;
        if (i_rst_n) begin
            in_accepted = i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                expected_angles.push_back(euler_from_quat(pending_quats[0]));
                void'(pending_quats.pop_front());
            end
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected result psi=%0d theta=%0d phi=%0d", $time,
                             o_psi_angle, o_theta_angle, o_phi_angle);
                    error_count++;
                end else begin
                    e = expected_angles.pop_front();
                    if (e.clamped) clamp_count++;
                    if (o_psi_angle !== e.psi) begin
                        $display("%0t: psi expected %0d actual %0d", $time, e.psi, o_psi_angle);
                        error_count++;
                    end
                    if (o_theta_angle !== e.theta) begin
                        $display("%0t: theta expected %0d actual %0d", $time, e.theta,
                                 o_theta_angle);
                        error_count++;
                    end
                    if (o_phi_angle !== e.phi) begin
                        $display("%0t: phi expected %0d actual %0d", $time, e.phi, o_phi_angle);
                        error_count++;
                    end
                    if (o_asin_clamped !== e.clamped) begin
                        $display("%0t: clamp flag expected %0b actual %0b", $time, e.clamped,
                                 o_asin_clamped);
                        error_count++;
                    end
                end
            end
        end
    end

    // Cycle counter and timeout.
    initial begin
        cycle_count = 0;
        error_count = 0;
        result_count = 0;
        clamp_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // End of run: drain, wait out the latency, report.
    initial begin
        wait (stimulus_done);
        wait (expected_angles.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_angles.size() != 0) begin
            $display("%0d results never arrived", expected_angles.size());
            error_count++;
        end
        $display("Checked %0d quaternions, %0d with a clamped asin argument, in %0d cycles.",
                 result_count, clamp_count, cycle_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
